FILE: rtl/rdpd_pkg.sv
`timescale 1ns / 1ps
// rdpd_pkg: types and constants shared by the rotary dial pulse decoder
// no dependencies; used by rdpd_step and rotary_dial_pulse_decoder
package rdpd_pkg;

   localparam int unsigned TIMER_W   = 16;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned CHAR_W    = 6;
   localparam int unsigned CSR_IDX_W = 4;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 4'd1;

   // register reset values
   localparam logic [TIMER_W-1:0] SETTLE_RESET   = 16'd50;
   localparam logic [TIMER_W-1:0] DEBOUNCE_RESET = 16'd40;

   // pulse count decoding
   localparam logic [COUNT_W-1:0] COUNT_ONE    = 4'd1;
   localparam logic [COUNT_W-1:0] COUNT_NINE   = 4'd9;
   localparam logic [COUNT_W-1:0] COUNT_TEN    = 4'd10;
   localparam logic [COUNT_W-1:0] COUNT_ELEVEN = 4'd11;
   localparam logic [COUNT_W-1:0] COUNT_TWELVE = 4'd12;
   localparam logic [COUNT_W-1:0] COUNT_SAT    = 4'd15;

   // ascii codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
   localparam logic [CHAR_W-1:0] CHAR_HASH = 6'd35;
   localparam logic [CHAR_W-1:0] CHAR_STAR = 6'd42;
   localparam logic [CHAR_W-1:0] CHAR_NONE = 6'd0;

   typedef enum logic [5:0] {
      PH_IDLE      = 6'b000001,
      PH_SETTLE    = 6'b000010,
      PH_WAIT_HIGH = 6'b000100,
      PH_DEB_HIGH  = 6'b001000,
      PH_WAIT_LOW  = 6'b010000,
      PH_DEB_LOW   = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [TIMER_W-1:0] timer;
      logic [COUNT_W-1:0] count;
   } dial_state_type;

   typedef struct packed {
      logic              digit_valid;
      logic [CHAR_W-1:0] digit_char;
      logic              digit_rejected;
      logic              dial_aborted;
      logic              dialing_busy;
   } dial_result_type;

endpackage

FILE: rtl/rdpd_step.sv
`timescale 1ns / 1ps
// rdpd_step: one tick of the dial sequencer, next state and result beat
// depends on rdpd_pkg
module rdpd_step (
   input  rdpd_pkg::dial_state_type        cur,
   input  logic                            hook_lifted,
   input  logic                            dial_engaged,
   input  logic                            pulse_contact,
   input  logic [rdpd_pkg::TIMER_W-1:0]    settle_ticks,
   input  logic [rdpd_pkg::TIMER_W-1:0]    debounce_ticks,
   output rdpd_pkg::dial_state_type        nxt,
   output rdpd_pkg::dial_result_type       res
);

   logic                           timer_last;
   logic [rdpd_pkg::TIMER_W-1:0]   timer_dec;
   logic [rdpd_pkg::COUNT_W-1:0]   count_inc;
   logic                           loop_test;
   logic [rdpd_pkg::COUNT_W-1:0]   test_count;

   assign timer_last = (cur.timer <= 16'd1);
   assign timer_dec  = cur.timer - 16'd1;
   assign count_inc  = (cur.count == rdpd_pkg::COUNT_SAT) ? cur.count
                                                          : cur.count + 4'd1;

   always_comb begin
      nxt        = cur;
      loop_test  = 1'b0;
      test_count = cur.count;
      unique case (cur.phase)
         rdpd_pkg::PH_SETTLE: begin
            if (timer_last) begin
               nxt.timer = '0;
               loop_test = 1'b1;
            end else begin
               nxt.timer = timer_dec;
            end
         end
         rdpd_pkg::PH_WAIT_HIGH: begin
            if (pulse_contact || !hook_lifted) begin
               nxt.timer = debounce_ticks;
               nxt.phase = rdpd_pkg::PH_DEB_HIGH;
            end
         end
         rdpd_pkg::PH_DEB_HIGH: begin
            if (timer_last) begin
               nxt.timer = '0;
               nxt.phase = rdpd_pkg::PH_WAIT_LOW;
            end else begin
               nxt.timer = timer_dec;
            end
         end
         rdpd_pkg::PH_WAIT_LOW: begin
            if (!pulse_contact || !hook_lifted) begin
               nxt.timer = debounce_ticks;
               nxt.phase = rdpd_pkg::PH_DEB_LOW;
            end
         end
         rdpd_pkg::PH_DEB_LOW: begin
            if (timer_last) begin
               nxt.timer  = '0;
               nxt.count  = count_inc;
               test_count = count_inc;
               loop_test  = 1'b1;
            end else begin
               nxt.timer = timer_dec;
            end
         end
         default: begin
            // idle, and any stray code
            nxt.phase = rdpd_pkg::PH_IDLE;
            if (hook_lifted && dial_engaged) begin
               nxt.count = '0;
               nxt.timer = settle_ticks;
               nxt.phase = rdpd_pkg::PH_SETTLE;
            end
         end
      endcase

      res            = '0;
      res.digit_char = rdpd_pkg::CHAR_NONE;
      if (loop_test) begin
         if (hook_lifted && dial_engaged) begin
            nxt.phase = rdpd_pkg::PH_WAIT_HIGH;
         end else begin
            nxt.phase = rdpd_pkg::PH_IDLE;
            if (!hook_lifted) begin
               res.dial_aborted = 1'b1;
            end else if (test_count >= rdpd_pkg::COUNT_ONE &&
                         test_count <= rdpd_pkg::COUNT_NINE) begin
               res.digit_valid = 1'b1;
               res.digit_char  = rdpd_pkg::CHAR_ZERO + {2'b00, test_count};
            end else if (test_count == rdpd_pkg::COUNT_TEN) begin
               res.digit_valid = 1'b1;
               res.digit_char  = rdpd_pkg::CHAR_ZERO;
            end else if (test_count == rdpd_pkg::COUNT_ELEVEN) begin
               res.digit_valid = 1'b1;
               res.digit_char  = rdpd_pkg::CHAR_HASH;
            end else if (test_count == rdpd_pkg::COUNT_TWELVE) begin
               res.digit_valid = 1'b1;
               res.digit_char  = rdpd_pkg::CHAR_STAR;
            end else begin
               // no pulses, or too many
               res.digit_rejected = 1'b1;
            end
         end
      end
      res.dialing_busy = (nxt.phase != rdpd_pkg::PH_IDLE);
   end

endmodule

FILE: rtl/rotary_dial_pulse_decoder.sv
`timescale 1ns / 1ps
// rotary_dial_pulse_decoder: top level, input register, dial sequencer and result register
// depends on rdpd_pkg and rdpd_step
// path: input register, then combinational state update, then result register
// throughput: one tick beat per cycle unless rsp_ready stalls the result register
// reset: synchronous, active high; sequencer idle, settle 50 / debounce 40, both registers empty
module rotary_dial_pulse_decoder (
   input  logic                              clock,
   input  logic                              reset,

   // tick beats
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_hook_lifted,
   input  logic                              req_dial_engaged,
   input  logic                              req_pulse_contact,

   // result beats
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_digit_valid,
   output logic [rdpd_pkg::CHAR_W-1:0]       rsp_digit_char,
   output logic                              rsp_digit_rejected,
   output logic                              rsp_dial_aborted,
   output logic                              rsp_dialing_busy,

   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rdpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rdpd_pkg::TIMER_W-1:0]      csr_wdata
);

   // configuration registers
   logic [rdpd_pkg::TIMER_W-1:0] settle_ff;
   logic [rdpd_pkg::TIMER_W-1:0] debounce_ff;

   // input register
   logic in_valid_ff;
   logic in_hook_ff;
   logic in_eng_ff;
   logic in_pulse_ff;

   // sequencer state
   rdpd_pkg::dial_state_type  state_ff;
   rdpd_pkg::dial_state_type  state_in;

   // result register
   logic                      out_valid_ff;
   rdpd_pkg::dial_result_type out_ff;
   rdpd_pkg::dial_result_type out_in;

   logic out_free;
   logic advance;

   // csr writes are always taken; unknown indexes fall away
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff   <= rdpd_pkg::SETTLE_RESET;
         debounce_ff <= rdpd_pkg::DEBOUNCE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rdpd_pkg::CSR_SETTLE:   settle_ff   <= csr_wdata;
            rdpd_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // the result register frees up when empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   // input register takes a new beat whenever it empties this cycle
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_hook_ff  <= req_hook_lifted;
         in_eng_ff   <= req_dial_engaged;
         in_pulse_ff <= req_pulse_contact;
      end
   end

   // one tick of the sequencer, applied as the beat moves to the result register
   rdpd_step u_step (
      .cur            (state_ff),
      .hook_lifted    (in_hook_ff),
      .dial_engaged   (in_eng_ff),
      .pulse_contact  (in_pulse_ff),
      .settle_ticks   (settle_ff),
      .debounce_ticks (debounce_ff),
      .nxt            (state_in),
      .res            (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= rdpd_pkg::PH_IDLE;
         state_ff.timer <= '0;
         state_ff.count <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_digit_valid    = out_ff.digit_valid;
   assign rsp_digit_char     = out_ff.digit_char;
   assign rsp_digit_rejected = out_ff.digit_rejected;
   assign rsp_dial_aborted   = out_ff.dial_aborted;
   assign rsp_dialing_busy   = out_ff.dialing_busy;

   // at most one way for dialing to end, and each one leaves the sequencer idle
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ($countones({out_ff.digit_valid, out_ff.digit_rejected,
                                    out_ff.dial_aborted}) <= 1))
      else $error("more than one dial outcome in a result beat");

   a_end_is_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.digit_valid || out_ff.digit_rejected ||
                       out_ff.dial_aborted) |-> !out_ff.dialing_busy)
      else $error("dial outcome reported while still busy");

   // no character without a digit
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.digit_valid |-> out_ff.digit_char == rdpd_pkg::CHAR_NONE)
      else $error("character set without a digit");

   // an idle sequencer never leaves a delay running
   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == rdpd_pkg::PH_IDLE |-> state_ff.timer == '0)
      else $error("delay timer running while idle");

   // a buffered beat moves on whenever the result side has room
   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_free |=> out_valid_ff)
      else $error("tick beat lost between input and result register");

endmodule
